// File: hw/rtl/tlvtsf_pkg.sv
package tlvtsf_pkg;

   // longest buffer taken before the search is cut short
   localparam int MaxBufferBytes = 65536;
   localparam int PosWidth       = $clog2(MaxBufferBytes + 1);

   localparam int HdrBytes = 4;

   // outcome codes, also used for the scan progress
   localparam logic [1:0] StatusNotFound  = 2'd0;
   localparam logic [1:0] StatusFound     = 2'd1;
   localparam logic [1:0] StatusTruncated = 2'd2;

   // header byte counter: 0..3 header bytes, 4 inside a payload
   localparam logic [2:0] HdrTypeLo  = 3'd0;
   localparam logic [2:0] HdrTypeHi  = 3'd1;
   localparam logic [2:0] HdrLenLo   = 3'd2;
   localparam logic [2:0] HdrLenHi   = 3'd3;
   localparam logic [2:0] HdrPayload = 3'd4;

   // register indexes of the configuration port
   localparam int          CsrIndexWidth       = 2;
   localparam logic [1:0] CsrTargetType       = 2'd0;
   localparam logic [1:0] CsrSizeCheckEnable  = 2'd1;
   localparam logic [1:0] CsrExpectedSize     = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] match_offset;
      logic [15:0] match_payload_length;
      logic        size_mismatch_seen;
   } rsp_type;

   typedef struct packed {
      logic [15:0] target_type;
      logic        size_check_enable;
      logic [16:0] expected_size;
   } cfg_type;

endpackage

// File: hw/rtl/tlv_type_size_finder_unit.sv
// channel  direction  handshake         carries
// req      in         req_valid/stall   req_type: data_byte, last_byte
// rsp      out        rsp_valid/stall   rsp_type: status, offset, length, mismatch
// csr      in         csr_valid/ready   csr_index, csr_wdata
//
// one byte per cycle unless a stall holds the input register; a byte
// passes through the input register, and the outcome of the last byte
// is captured in the result register
// only the byte marked last waits on a stalled result register
// reset is synchronous and clears the scan state, the configuration and the valid flags
// the scan state returns to reset after each last byte
module tlv_type_size_finder_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  tlvtsf_pkg::req_type                  req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output tlvtsf_pkg::rsp_type                  rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tlvtsf_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [31:0]                          csr_wdata
);

   logic                in_valid_ff, in_valid_in;
   tlvtsf_pkg::req_type in_item_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   tlvtsf_pkg::rsp_type rsp_payload_ff;
   tlvtsf_pkg::rsp_type scan_result;
   tlvtsf_pkg::cfg_type cfg;
   logic                advance;
   logic                req_xfer;

   tlvtsf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr_ready (csr_ready),
      .cfg       (cfg)
   );

   tlvtsf_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (scan_result)
   );

   // a last byte needs room in the result register
   assign advance   = in_valid_ff &&
                      (!in_item_ff.last_byte || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_xfer  = req_valid && !req_stall;

   assign in_valid_in  = req_xfer || (in_valid_ff && !advance);
   assign rsp_valid_in = (advance && in_item_ff.last_byte) ||
                         (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_item_ff <= req_payload;
      end
      if (advance && in_item_ff.last_byte) begin
         rsp_payload_ff <= scan_result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// File: hw/rtl/tlvtsf_csr.sv
module tlvtsf_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [tlvtsf_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [31:0]                          csr_wdata,
   output logic                                 csr_ready,
   output tlvtsf_pkg::cfg_type                  cfg
);

   tlvtsf_pkg::cfg_type cfg_ff, cfg_in;
   logic                wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid & csr_ready;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_index)
            tlvtsf_pkg::CsrTargetType:      cfg_in.target_type       = csr_wdata[15:0];
            tlvtsf_pkg::CsrSizeCheckEnable: cfg_in.size_check_enable = csr_wdata[0];
            tlvtsf_pkg::CsrExpectedSize:    cfg_in.expected_size     = csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_type       <= 16'd0;
         cfg_ff.size_check_enable <= 1'b0;
         cfg_ff.expected_size     <= 17'(tlvtsf_pkg::HdrBytes);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hw/rtl/tlvtsf_scan.sv
module tlvtsf_scan (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  tlvtsf_pkg::req_type item,
   input  tlvtsf_pkg::cfg_type cfg,
   output tlvtsf_pkg::rsp_type result
);

   localparam int PW = tlvtsf_pkg::PosWidth;

   logic [PW-1:0] pos_ff, pos_in;
   logic [2:0]    hdr_idx_ff, hdr_idx_in;
   logic [15:0]   rec_type_ff, rec_type_in;
   logic [15:0]   rec_len_ff, rec_len_in;
   logic [15:0]   remaining_ff, remaining_in;
   logic [15:0]   rec_start_ff, rec_start_in;
   logic [1:0]    done_ff, done_in;
   logic [15:0]   found_off_ff, found_off_in;
   logic [15:0]   found_len_ff, found_len_in;
   logic          mismatch_ff, mismatch_in;

   logic [15:0] len_full;
   logic        rec_complete;
   logic        type_hit;
   logic        size_ok;

   // length as it stands once this byte is in
   assign len_full = (hdr_idx_ff == tlvtsf_pkg::HdrLenHi) ?
                     {item.data_byte, rec_len_ff[7:0]} : rec_len_ff;

   assign type_hit = (rec_type_ff == cfg.target_type);
   assign size_ok  = !cfg.size_check_enable ||
                     (({1'b0, len_full} + 17'(tlvtsf_pkg::HdrBytes)) == cfg.expected_size);

   always_comb begin
      pos_in       = pos_ff;
      hdr_idx_in   = hdr_idx_ff;
      rec_type_in  = rec_type_ff;
      rec_len_in   = rec_len_ff;
      remaining_in = remaining_ff;
      rec_start_in = rec_start_ff;
      done_in      = done_ff;
      found_off_in = found_off_ff;
      found_len_in = found_len_ff;
      mismatch_in  = mismatch_ff;
      rec_complete = 1'b0;

      if (done_ff == tlvtsf_pkg::StatusNotFound) begin
         if (pos_ff >= PW'(tlvtsf_pkg::MaxBufferBytes)) begin
            done_in = tlvtsf_pkg::StatusTruncated;
         end else begin
            pos_in = pos_ff + PW'(1);
            unique case (hdr_idx_ff)
               tlvtsf_pkg::HdrTypeLo: begin
                  rec_start_in = pos_ff[15:0];
                  rec_type_in  = {8'd0, item.data_byte};
                  hdr_idx_in   = tlvtsf_pkg::HdrTypeHi;
               end
               tlvtsf_pkg::HdrTypeHi: begin
                  rec_type_in = {item.data_byte, rec_type_ff[7:0]};
                  hdr_idx_in  = tlvtsf_pkg::HdrLenLo;
               end
               tlvtsf_pkg::HdrLenLo: begin
                  rec_len_in = {8'd0, item.data_byte};
                  hdr_idx_in = tlvtsf_pkg::HdrLenHi;
               end
               tlvtsf_pkg::HdrLenHi: begin
                  rec_len_in   = len_full;
                  remaining_in = len_full;
                  hdr_idx_in   = tlvtsf_pkg::HdrPayload;
                  rec_complete = (len_full == 16'd0);
               end
               default: begin
                  remaining_in = remaining_ff - 16'd1;
                  rec_complete = (remaining_ff == 16'd1);
               end
            endcase

            if (rec_complete) begin
               hdr_idx_in = tlvtsf_pkg::HdrTypeLo;
               if (type_hit) begin
                  if (size_ok) begin
                     done_in      = tlvtsf_pkg::StatusFound;
                     found_off_in = rec_start_ff;
                     found_len_in = len_full;
                  end else begin
                     mismatch_in = 1'b1;
                  end
               end
            end
         end
      end
   end

   // outcome as seen after this byte, only used on the last byte
   always_comb begin
      result = '0;
      if (done_in == tlvtsf_pkg::StatusFound) begin
         result.status               = tlvtsf_pkg::StatusFound;
         result.match_offset         = found_off_in;
         result.match_payload_length = found_len_in;
      end else if (done_in == tlvtsf_pkg::StatusTruncated ||
                   hdr_idx_in != tlvtsf_pkg::HdrTypeLo) begin
         result.status = tlvtsf_pkg::StatusTruncated;
      end else begin
         result.status = tlvtsf_pkg::StatusNotFound;
      end
      result.size_mismatch_seen = mismatch_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && item.last_byte)) begin
         pos_ff       <= '0;
         hdr_idx_ff   <= tlvtsf_pkg::HdrTypeLo;
         rec_type_ff  <= '0;
         rec_len_ff   <= '0;
         remaining_ff <= '0;
         rec_start_ff <= '0;
         done_ff      <= tlvtsf_pkg::StatusNotFound;
         found_off_ff <= '0;
         found_len_ff <= '0;
         mismatch_ff  <= 1'b0;
      end else if (step) begin
         pos_ff       <= pos_in;
         hdr_idx_ff   <= hdr_idx_in;
         rec_type_ff  <= rec_type_in;
         rec_len_ff   <= rec_len_in;
         remaining_ff <= remaining_in;
         rec_start_ff <= rec_start_in;
         done_ff      <= done_in;
         found_off_ff <= found_off_in;
         found_len_ff <= found_len_in;
         mismatch_ff  <= mismatch_in;
      end
   end

endmodule

// File: hw/rtl/tlvtsf_checker.sv
module tlvtsf_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input tlvtsf_pkg::rsp_type rsp_payload
);

   // a held result keeps its contents
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.status == tlvtsf_pkg::StatusNotFound ||
                    rsp_payload.status == tlvtsf_pkg::StatusFound ||
                    rsp_payload.status == tlvtsf_pkg::StatusTruncated)
      else $error("unused status code");

   // no match means no offset and no length
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != tlvtsf_pkg::StatusFound |->
         rsp_payload.match_offset == 16'd0 && rsp_payload.match_payload_length == 16'd0)
      else $error("match fields set without a match");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown straight after reset");

endmodule

bind tlv_type_size_finder_unit tlvtsf_checker u_tlvtsf_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
